// File: rtl/obdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package obdf_pkg;

  localparam int unsigned MAX_LEVELS = 1024;
  localparam int unsigned RANK_W     = $clog2(MAX_LEVELS + 1);

  localparam int unsigned PRICE_W  = 40;
  localparam int unsigned SIZE_W   = 48;
  localparam int unsigned SUM_W    = 58;
  localparam int unsigned TOP_W    = 7;
  localparam int unsigned BAND_W   = 14;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned SPREAD_W = 24;
  localparam int unsigned MID_W    = PRICE_W + 1;
  localparam int unsigned BANDP_W  = 56;

  localparam logic [TOP_W-1:0]  TOP_MIN   = 7'd1;
  localparam logic [TOP_W-1:0]  TOP_MAX   = 7'd64;
  localparam logic [TOP_W-1:0]  TOP_RST   = 7'd10;
  localparam logic [BAND_W-1:0] BP_FULL   = 14'd10000;
  localparam logic [BAND_W-1:0] BAND_RST  = 14'd50;
  localparam logic [15:0]       BP_TWICE  = 16'd20000;

  // 2 * 10000 * 256 = 625 << 13
  localparam logic [9:0]  SPREAD_MULT  = 10'd625;
  localparam int unsigned SPREAD_SHIFT = 13;
  localparam int unsigned SPREAD_Q_W   = 23;

  localparam int unsigned FRAC_STEPS = 16;
  localparam int unsigned DIV_STEPS  = SPREAD_Q_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
  localparam logic [FRAC_W-1:0] FRAC_HALF = 17'd32768;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic REG_TOP_LEVELS = 1'b0;
  localparam logic REG_DEPTH_BAND = 1'b1;

  typedef struct packed {
    logic [PRICE_W-1:0] top_bid_px;
    logic [PRICE_W-1:0] top_ask_px;
    logic [SUM_W-1:0]   bid_top;
    logic [SUM_W-1:0]   ask_top;
    logic [SIZE_W-1:0]  bid_max;
    logic [SIZE_W-1:0]  ask_max;
    logic [SUM_W-1:0]   bid_band;
    logic [SUM_W-1:0]   ask_band;
  } snap_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SIZE_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/obdf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module obdf_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [obdf_pkg::TOP_W-1:0]      top_levels_i,
  input  wire logic [obdf_pkg::BAND_W-1:0]     band_i,
  input  wire logic [obdf_pkg::PRICE_W-1:0]    bid_price_i,
  input  wire logic [obdf_pkg::SIZE_W-1:0]     bid_size_i,
  input  wire logic                            bid_valid_i,
  input  wire logic [obdf_pkg::PRICE_W-1:0]    ask_price_i,
  input  wire logic [obdf_pkg::SIZE_W-1:0]     ask_size_i,
  input  wire logic                            ask_valid_i,
  input  wire logic                            last_level_i,
  output logic                                 push_o,
  output obdf_pkg::snap_t                      snap_o
);

  logic [obdf_pkg::RANK_W-1:0] rank_q, rank_d;
  obdf_pkg::snap_t             st_q, st_d, nb;
  logic                        bid_stop_q, bid_stop_d, ask_stop_q, ask_stop_d;
  logic                        nb_bid_stop, nb_ask_stop;

  logic                          active, first, in_top;
  logic [obdf_pkg::MID_W-1:0]    msum;
  logic [obdf_pkg::BAND_W-1:0]   lo_fac;
  logic [obdf_pkg::BAND_W:0]     hi_fac;
  logic [obdf_pkg::BANDP_W-1:0]  lo, hi, bid2, ask2;

  always_comb begin
    active = rank_q < obdf_pkg::RANK_W'(obdf_pkg::MAX_LEVELS);
    first  = rank_q == '0;
    in_top = rank_q < obdf_pkg::RANK_W'(top_levels_i);
    nb          = st_q;
    nb_bid_stop = bid_stop_q;
    nb_ask_stop = ask_stop_q;
    if (first) begin
      nb.top_bid_px = bid_valid_i ? bid_price_i : '0;
      nb.top_ask_px = ask_valid_i ? ask_price_i : '0;
    end
    // band edges around the mid, everything scaled by 2 * 10000
    msum   = obdf_pkg::MID_W'(nb.top_bid_px) + obdf_pkg::MID_W'(nb.top_ask_px);
    lo_fac = obdf_pkg::BP_FULL - band_i;
    hi_fac = {1'b0, obdf_pkg::BP_FULL} + {1'b0, band_i};
    lo     = obdf_pkg::BANDP_W'(msum) * obdf_pkg::BANDP_W'(lo_fac);
    hi     = obdf_pkg::BANDP_W'(msum) * obdf_pkg::BANDP_W'(hi_fac);
    bid2   = obdf_pkg::BANDP_W'(bid_price_i) * obdf_pkg::BANDP_W'(obdf_pkg::BP_TWICE);
    ask2   = obdf_pkg::BANDP_W'(ask_price_i) * obdf_pkg::BANDP_W'(obdf_pkg::BP_TWICE);
    if (in_top && bid_valid_i) begin
      nb.bid_top = obdf_pkg::sat_add(st_q.bid_top, bid_size_i);
      if (bid_size_i > st_q.bid_max) nb.bid_max = bid_size_i;
    end
    if (in_top && ask_valid_i) begin
      nb.ask_top = obdf_pkg::sat_add(st_q.ask_top, ask_size_i);
      if (ask_size_i > st_q.ask_max) nb.ask_max = ask_size_i;
    end
    if (bid_valid_i && !bid_stop_q) begin
      if (bid2 >= lo) nb.bid_band = obdf_pkg::sat_add(st_q.bid_band, bid_size_i);
      else            nb_bid_stop = 1'b1;
    end
    if (ask_valid_i && !ask_stop_q) begin
      if (ask2 <= hi) nb.ask_band = obdf_pkg::sat_add(st_q.ask_band, ask_size_i);
      else            nb_ask_stop = 1'b1;
    end
    if (!active) begin
      nb          = st_q;
      nb_bid_stop = bid_stop_q;
      nb_ask_stop = ask_stop_q;
    end

    rank_d     = rank_q;
    st_d       = st_q;
    bid_stop_d = bid_stop_q;
    ask_stop_d = ask_stop_q;
    push_o     = 1'b0;
    snap_o     = nb;
    if (accept_i) begin
      if (last_level_i) begin
        push_o     = 1'b1;
        rank_d     = '0;
        st_d       = '0;
        bid_stop_d = 1'b0;
        ask_stop_d = 1'b0;
      end else begin
        rank_d     = active ? rank_q + 1'b1 : rank_q;
        st_d       = nb;
        bid_stop_d = nb_bid_stop;
        ask_stop_d = nb_ask_stop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q     <= '0;
      st_q       <= '0;
      bid_stop_q <= 1'b0;
      ask_stop_q <= 1'b0;
    end else begin
      rank_q     <= rank_d;
      st_q       <= st_d;
      bid_stop_q <= bid_stop_d;
      ask_stop_q <= ask_stop_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/obdf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module obdf_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire obdf_pkg::snap_t  push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output obdf_pkg::snap_t       pop_data_o
);

  obdf_pkg::snap_t              mem_q [obdf_pkg::Q_DEPTH];
  logic [obdf_pkg::Q_PTR_W-1:0] wr_q, rd_q;
  logic [obdf_pkg::Q_CNT_W-1:0] cnt_q;

  assign full_o     = cnt_q == obdf_pkg::Q_CNT_W'(obdf_pkg::Q_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + obdf_pkg::Q_CNT_W'(push_i) - obdf_pkg::Q_CNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("snapshot queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("snapshot queue underflow");

endmodule
`default_nettype wire

// File: rtl/obdf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module obdf_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              empty_i,
  input  wire obdf_pkg::snap_t                   snap_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [obdf_pkg::FRAC_W-1:0]            imbalance_frac_o,
  output logic [obdf_pkg::FRAC_W-1:0]            depth_ratio_frac_o,
  output logic [obdf_pkg::FRAC_W-1:0]            wall_frac_o,
  output logic signed [obdf_pkg::SPREAD_W-1:0]   spread_bps_q8_o,
  output logic [obdf_pkg::PRICE_W-1:0]           best_bid_out_o,
  output logic [obdf_pkg::PRICE_W-1:0]           best_ask_out_o,
  output logic [obdf_pkg::SUM_W-1:0]             bid_top_volume_o,
  output logic [obdf_pkg::SUM_W-1:0]             ask_top_volume_o,
  output logic [obdf_pkg::SUM_W-1:0]             bid_band_volume_o,
  output logic [obdf_pkg::SUM_W-1:0]             ask_band_volume_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam int unsigned DW = obdf_pkg::SUM_W + 1;
  localparam int unsigned MW = obdf_pkg::MID_W;
  localparam int unsigned QW = obdf_pkg::SPREAD_Q_W;

  logic [2:0]                  state_q, state_d;
  logic [obdf_pkg::CNT_W-1:0]  cnt_q;
  obdf_pkg::snap_t             snap_q;

  logic [DW-1:0]               top_tot_q, band_tot_q;
  logic [obdf_pkg::SIZE_W-1:0] wall_q;
  logic [MW-1:0]               den_q;
  logic [obdf_pkg::PRICE_W-1:0] diff_q;
  logic                        neg_q;

  // three fraction lanes: imbalance, band ratio, wall
  logic [DW-1:0]               fr_d_q [3];
  logic [DW-1:0]               fr_r_q [3];
  logic [obdf_pkg::FRAC_STEPS-1:0] fr_q_q [3];
  logic [2:0]                  fr_full_q, fr_zero_q;
  logic [DW-1:0]               ln_n [3];
  logic [DW-1:0]               ln_d [3];
  logic [DW:0]                 fr_t [3];
  logic [obdf_pkg::FRAC_W-1:0] fr_res [3];
  logic [obdf_pkg::FRAC_W-1:0] fr_dflt [3];

  // spread long division
  logic [63:0]                 num;
  logic [MW-1:0]               sr_q;
  logic [QW-1:0]               slo_q, sq_q;
  logic [MW:0]                 s_t;
  logic signed [obdf_pkg::SPREAD_W-1:0] spread;

  logic load_out;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign load_out = (state_q == S_DONE) && (!out_valid_o || !out_stall_i);

  always_comb begin
    ln_n[0] = DW'(snap_q.bid_top);
    ln_d[0] = top_tot_q;
    ln_n[1] = DW'(snap_q.bid_band);
    ln_d[1] = band_tot_q;
    ln_n[2] = DW'(wall_q);
    ln_d[2] = top_tot_q;
    fr_dflt[0] = obdf_pkg::FRAC_HALF;
    fr_dflt[1] = obdf_pkg::FRAC_HALF;
    fr_dflt[2] = '0;
    for (int i = 0; i < 3; i++) begin
      fr_t[i] = {fr_r_q[i], 1'b0};
      if (fr_zero_q[i])      fr_res[i] = fr_dflt[i];
      else if (fr_full_q[i]) fr_res[i] = obdf_pkg::FRAC_ONE;
      else fr_res[i] = obdf_pkg::FRAC_W'(fr_q_q[i])
                     + obdf_pkg::FRAC_W'(fr_t[i] >= {1'b0, fr_d_q[i]});
    end
    num = ((64'(diff_q) * 64'(obdf_pkg::SPREAD_MULT)) << obdf_pkg::SPREAD_SHIFT)
        + 64'(den_q >> 1);
    s_t = {sr_q, slo_q[QW-1]};
    if (den_q == '0)  spread = '0;
    else if (neg_q)   spread = obdf_pkg::SPREAD_W'(-{1'b0, sq_q});
    else              spread = obdf_pkg::SPREAD_W'({1'b0, sq_q});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (!empty_i) state_d = S_SETUP;
      S_SETUP: state_d = S_PREP;
      S_PREP:  state_d = S_DIV;
      S_DIV:   if (cnt_q == obdf_pkg::CNT_W'(obdf_pkg::DIV_STEPS - 1)) state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DIV) cnt_q <= cnt_q + 1'b1;
      else                  cnt_q <= '0;
      if (load_out)         out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) snap_q <= snap_i;
    if (state_q == S_SETUP) begin
      top_tot_q  <= DW'(snap_q.bid_top) + DW'(snap_q.ask_top);
      band_tot_q <= DW'(snap_q.bid_band) + DW'(snap_q.ask_band);
      wall_q     <= (snap_q.bid_max > snap_q.ask_max) ? snap_q.bid_max : snap_q.ask_max;
      den_q      <= MW'(snap_q.top_bid_px) + MW'(snap_q.top_ask_px);
      neg_q      <= snap_q.top_ask_px < snap_q.top_bid_px;
      diff_q     <= (snap_q.top_ask_px < snap_q.top_bid_px)
                    ? snap_q.top_bid_px - snap_q.top_ask_px
                    : snap_q.top_ask_px - snap_q.top_bid_px;
    end
    if (state_q == S_PREP) begin
      for (int i = 0; i < 3; i++) begin
        fr_d_q[i]    <= ln_d[i];
        fr_r_q[i]    <= ln_n[i];
        fr_q_q[i]    <= '0;
        fr_full_q[i] <= ln_n[i] >= ln_d[i];
        fr_zero_q[i] <= ln_d[i] == '0;
      end
      sr_q  <= num[63:QW];
      slo_q <= num[QW-1:0];
      sq_q  <= '0;
    end
    if (state_q == S_DIV) begin
      if (cnt_q < obdf_pkg::CNT_W'(obdf_pkg::FRAC_STEPS)) begin
        for (int i = 0; i < 3; i++) begin
          if (fr_t[i] >= {1'b0, fr_d_q[i]}) begin
            fr_r_q[i] <= DW'(fr_t[i] - {1'b0, fr_d_q[i]});
            fr_q_q[i] <= {fr_q_q[i][obdf_pkg::FRAC_STEPS-2:0], 1'b1};
          end else begin
            fr_r_q[i] <= DW'(fr_t[i]);
            fr_q_q[i] <= {fr_q_q[i][obdf_pkg::FRAC_STEPS-2:0], 1'b0};
          end
        end
      end
      slo_q <= {slo_q[QW-2:0], 1'b0};
      if (s_t >= {1'b0, den_q}) begin
        sr_q <= MW'(s_t - {1'b0, den_q});
        sq_q <= {sq_q[QW-2:0], 1'b1};
      end else begin
        sr_q <= MW'(s_t);
        sq_q <= {sq_q[QW-2:0], 1'b0};
      end
    end
    if (load_out) begin
      imbalance_frac_o   <= fr_res[0];
      depth_ratio_frac_o <= fr_res[1];
      wall_frac_o        <= fr_res[2];
      spread_bps_q8_o    <= spread;
      best_bid_out_o     <= snap_q.top_bid_px;
      best_ask_out_o     <= snap_q.top_ask_px;
      bid_top_volume_o   <= snap_q.bid_top;
      ask_top_volume_o   <= snap_q.ask_top;
      bid_band_volume_o  <= snap_q.bid_band;
      ask_band_volume_o  <= snap_q.ask_band;
    end
  end

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_SETUP)
    else $error("snapshot popped without starting work");

  a_frac_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (imbalance_frac_o <= obdf_pkg::FRAC_ONE)
                 && (wall_frac_o <= obdf_pkg::FRAC_ONE))
    else $error("fraction above one");

endmodule
`default_nettype wire

// File: rtl/order_book_depth_features.sv
`timescale 1ns / 1ps
`default_nettype none
// flow: after the transfer of its last level, a snapshot goes through the queue pop,
//   setup, prep, 23 steps of the shared-step divider lanes and finish to the output register
// throughput: one level per cycle while the queue is not full; the back end takes a new
//   snapshot only when done with the last one, with a two-snapshot queue in front of it
// reset: rst_ni is asynchronous, active low; clears the snapshot, the queue and the
//   output valid, and sets top_levels to 10 and depth_band_bp to 50
module order_book_depth_features (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // config port
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [2:0]                             paddr,
  input  wire logic [31:0]                            pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready,
  // level input
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [obdf_pkg::PRICE_W-1:0]           bid_price_i,
  input  wire logic [obdf_pkg::SIZE_W-1:0]            bid_size_i,
  input  wire logic                                   bid_valid_i,
  input  wire logic [obdf_pkg::PRICE_W-1:0]           ask_price_i,
  input  wire logic [obdf_pkg::SIZE_W-1:0]            ask_size_i,
  input  wire logic                                   ask_valid_i,
  input  wire logic                                   last_level_i,
  // feature output
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [obdf_pkg::FRAC_W-1:0]                 imbalance_frac_o,
  output logic [obdf_pkg::FRAC_W-1:0]                 depth_ratio_frac_o,
  output logic [obdf_pkg::FRAC_W-1:0]                 wall_frac_o,
  output logic signed [obdf_pkg::SPREAD_W-1:0]        spread_bps_q8_o,
  output logic [obdf_pkg::PRICE_W-1:0]                best_bid_out_o,
  output logic [obdf_pkg::PRICE_W-1:0]                best_ask_out_o,
  output logic [obdf_pkg::SUM_W-1:0]                  bid_top_volume_o,
  output logic [obdf_pkg::SUM_W-1:0]                  ask_top_volume_o,
  output logic [obdf_pkg::SUM_W-1:0]                  bid_band_volume_o,
  output logic [obdf_pkg::SUM_W-1:0]                  ask_band_volume_o
);

  logic [obdf_pkg::TOP_W-1:0]  top_levels_q, tl_eff;
  logic [obdf_pkg::BAND_W-1:0] band_q, band_eff;
  logic                        cfg_wr, in_accept;
  logic                        push, full, pop, empty;
  obdf_pkg::snap_t             push_snap, pop_snap;

  // register at 4*i; paddr[2] selects the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      obdf_pkg::REG_TOP_LEVELS: prdata = 32'(top_levels_q);
      obdf_pkg::REG_DEPTH_BAND: prdata = 32'(band_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_levels_q <= obdf_pkg::TOP_RST;
      band_q       <= obdf_pkg::BAND_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == obdf_pkg::REG_TOP_LEVELS) top_levels_q <= pwdata[obdf_pkg::TOP_W-1:0];
      else                                      band_q <= pwdata[obdf_pkg::BAND_W-1:0];
    end
  end

  // out-of-range settings are clamped, not rejected
  always_comb begin
    if (top_levels_q < obdf_pkg::TOP_MIN)      tl_eff = obdf_pkg::TOP_MIN;
    else if (top_levels_q > obdf_pkg::TOP_MAX) tl_eff = obdf_pkg::TOP_MAX;
    else                                       tl_eff = top_levels_q;
    band_eff = (band_q > obdf_pkg::BP_FULL) ? obdf_pkg::BP_FULL : band_q;
  end

  // the front stalls only while the snapshot queue is full
  assign in_stall_o = full;
  assign in_accept  = in_valid_i && !in_stall_o;

  obdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .top_levels_i (tl_eff),
    .band_i       (band_eff),
    .bid_price_i  (bid_price_i),
    .bid_size_i   (bid_size_i),
    .bid_valid_i  (bid_valid_i),
    .ask_price_i  (ask_price_i),
    .ask_size_i   (ask_size_i),
    .ask_valid_i  (ask_valid_i),
    .last_level_i (last_level_i),
    .push_o       (push),
    .snap_o       (push_snap)
  );

  obdf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_snap),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_snap)
  );

  // back end: divisions and the output register
  obdf_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (empty),
    .snap_i             (pop_snap),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .imbalance_frac_o   (imbalance_frac_o),
    .depth_ratio_frac_o (depth_ratio_frac_o),
    .wall_frac_o        (wall_frac_o),
    .spread_bps_q8_o    (spread_bps_q8_o),
    .best_bid_out_o     (best_bid_out_o),
    .best_ask_out_o     (best_ask_out_o),
    .bid_top_volume_o   (bid_top_volume_o),
    .ask_top_volume_o   (ask_top_volume_o),
    .bid_band_volume_o  (bid_band_volume_o),
    .ask_band_volume_o  (ask_band_volume_o)
  );

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  // one book rank as offered on the level input
  typedef struct {
    logic [obdf_pkg::PRICE_W-1:0] bid_px;
    logic [obdf_pkg::SIZE_W-1:0]  bid_sz;
    logic                         bid_ok;
    logic [obdf_pkg::PRICE_W-1:0] ask_px;
    logic [obdf_pkg::SIZE_W-1:0]  ask_sz;
    logic                         ask_ok;
    logic                         last;
  } level_t;

  // one feature record as seen on the output
  typedef struct {
    logic [obdf_pkg::FRAC_W-1:0]   imb;
    logic [obdf_pkg::FRAC_W-1:0]   depth;
    logic [obdf_pkg::FRAC_W-1:0]   wall;
    logic [obdf_pkg::SPREAD_W-1:0] spread;
    logic [obdf_pkg::PRICE_W-1:0]  bb;
    logic [obdf_pkg::PRICE_W-1:0]  ba;
    logic [obdf_pkg::SUM_W-1:0]    bt;
    logic [obdf_pkg::SUM_W-1:0]    at;
    logic [obdf_pkg::SUM_W-1:0]    bband;
    logic [obdf_pkg::SUM_W-1:0]    aband;
  } feature_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_stall_o;
  logic [obdf_pkg::PRICE_W-1:0] bid_price_i, ask_price_i;
  logic [obdf_pkg::SIZE_W-1:0]  bid_size_i, ask_size_i;
  logic bid_valid_i, ask_valid_i, last_level_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [obdf_pkg::FRAC_W-1:0] imbalance_frac_o, depth_ratio_frac_o, wall_frac_o;
  logic signed [obdf_pkg::SPREAD_W-1:0] spread_bps_q8_o;
  logic [obdf_pkg::PRICE_W-1:0] best_bid_out_o, best_ask_out_o;
  logic [obdf_pkg::SUM_W-1:0] bid_top_volume_o, ask_top_volume_o;
  logic [obdf_pkg::SUM_W-1:0] bid_band_volume_o, ask_band_volume_o;

  order_book_depth_features uut (.*);

  // 50 MHz clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------
  // book feature predictor: its own copy of config and snapshot state
  // ---------------------------------------------------------------
  logic [63:0] cfg_top, cfg_band;
  int unsigned ranks_seen;
  logic [63:0] bid_best, ask_best;
  logic [63:0] bid_top_acc, ask_top_acc, bid_top_peak, ask_top_peak;
  logic [63:0] bid_band_acc, ask_band_acc;
  bit bid_band_done, ask_band_done;

  localparam logic [63:0] SUM_CAP = (64'd1 << obdf_pkg::SUM_W) - 64'd1;
  localparam logic [63:0] BP_ONE  = 64'd10000;

  level_t   level_q[$];
  feature_t feature_q[$];
  int errors = 0;
  int levels_sent = 0;
  int features_seen = 0;

  function automatic logic [63:0] sum_clip(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > SUM_CAP) ? SUM_CAP : s;
  endfunction

  // n/d in Q1.16, nearest with half up, capped at one
  function automatic logic [63:0] q16_ratio(logic [63:0] n, logic [63:0] d);
    logic [63:0] q, r;
    q = 0;
    r = n;
    if (n >= d) return 64'd65536;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    if (2 * r >= d) q = q + 1;
    return q;
  endfunction

  task automatic clear_book();
    ranks_seen = 0;
    bid_best = 0;
    ask_best = 0;
    bid_top_acc = 0;
    ask_top_acc = 0;
    bid_top_peak = 0;
    ask_top_peak = 0;
    bid_band_acc = 0;
    ask_band_acc = 0;
    bid_band_done = 0;
    ask_band_done = 0;
  endtask

  // fold one accepted rank into the book, queue features on the last rank
  task automatic book_accumulate(level_t lv);
    logic [63:0] tl, band, mid2, lo, hi, top_tot, band_tot, peak, diff, mag;
    feature_t f;
    bit neg;
    tl = (cfg_top < 1) ? 64'd1 : (cfg_top > 64) ? 64'd64 : cfg_top;
    band = (cfg_band > BP_ONE) ? BP_ONE : cfg_band;
    if (ranks_seen < obdf_pkg::MAX_LEVELS) begin
      if (ranks_seen == 0) begin
        bid_best = lv.bid_ok ? 64'(lv.bid_px) : 64'd0;
        ask_best = lv.ask_ok ? 64'(lv.ask_px) : 64'd0;
      end
      if (ranks_seen < tl) begin
        if (lv.bid_ok) begin
          bid_top_acc = sum_clip(bid_top_acc, 64'(lv.bid_sz));
          if (64'(lv.bid_sz) > bid_top_peak) bid_top_peak = 64'(lv.bid_sz);
        end
        if (lv.ask_ok) begin
          ask_top_acc = sum_clip(ask_top_acc, 64'(lv.ask_sz));
          if (64'(lv.ask_sz) > ask_top_peak) ask_top_peak = 64'(lv.ask_sz);
        end
      end
      // band edges scaled by 2*10000 to stay in integers
      mid2 = bid_best + ask_best;
      lo = mid2 * (BP_ONE - band);
      hi = mid2 * (BP_ONE + band);
      if (lv.bid_ok && !bid_band_done) begin
        if (2 * 64'(lv.bid_px) * BP_ONE >= lo)
          bid_band_acc = sum_clip(bid_band_acc, 64'(lv.bid_sz));
        else
          bid_band_done = 1;
      end
      if (lv.ask_ok && !ask_band_done) begin
        if (2 * 64'(lv.ask_px) * BP_ONE <= hi)
          ask_band_acc = sum_clip(ask_band_acc, 64'(lv.ask_sz));
        else
          ask_band_done = 1;
      end
      ranks_seen++;
    end
    if (lv.last) begin
      top_tot = bid_top_acc + ask_top_acc;
      band_tot = bid_band_acc + ask_band_acc;
      peak = (bid_top_peak > ask_top_peak) ? bid_top_peak : ask_top_peak;
      f.imb = obdf_pkg::FRAC_W'(top_tot != 0 ? q16_ratio(bid_top_acc, top_tot)
                                               : 64'd32768);
      f.depth = obdf_pkg::FRAC_W'(band_tot != 0 ? q16_ratio(bid_band_acc, band_tot)
                                                  : 64'd32768);
      f.wall = obdf_pkg::FRAC_W'(top_tot != 0 ? q16_ratio(peak, top_tot) : 64'd0);
      mid2 = bid_best + ask_best;
      mag = 0;
      neg = ask_best < bid_best;
      if (mid2 != 0) begin
        diff = neg ? bid_best - ask_best : ask_best - bid_best;
        mag = (diff * 64'd5120000 + mid2 / 2) / mid2;
      end
      f.spread = obdf_pkg::SPREAD_W'(neg ? -mag : mag);
      f.bb = obdf_pkg::PRICE_W'(bid_best);
      f.ba = obdf_pkg::PRICE_W'(ask_best);
      f.bt = obdf_pkg::SUM_W'(bid_top_acc);
      f.at = obdf_pkg::SUM_W'(ask_top_acc);
      f.bband = obdf_pkg::SUM_W'(bid_band_acc);
      f.aband = obdf_pkg::SUM_W'(ask_band_acc);
      feature_q.push_back(f);
      clear_book();
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (record %0d)", what, got, want,
             features_seen);
  endtask

  // ---------------------------------------------------------------
  // idle lengths: mostly none or short, a few long
  // ---------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------
  // level driver: a transfer is seen at the rising edge, the next level
  // is put up at the falling edge
  // ---------------------------------------------------------------
  bit level_taken = 0;
  int send_gap = 0;
  bit burst = 0;

  always @(negedge clk_i) begin
    level_t lv;
    if (!in_valid_i || level_taken) begin
      level_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (level_q.size() > 0) begin
        lv = level_q.pop_front();
        bid_price_i  <= lv.bid_px;
        bid_size_i   <= lv.bid_sz;
        bid_valid_i  <= lv.bid_ok;
        ask_price_i  <= lv.ask_px;
        ask_size_i   <= lv.ask_sz;
        ask_valid_i  <= lv.ask_ok;
        last_level_i <= lv.last;
        in_valid_i   <= 1'b1;
        // stretches with no idling at all
        if ($urandom_range(0, 49) == 0) burst = !burst;
        send_gap = burst ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // level transfers feed the predictor
  always @(posedge clk_i) begin
    level_t lv;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      lv.bid_px = bid_price_i;
      lv.bid_sz = bid_size_i;
      lv.bid_ok = bid_valid_i;
      lv.ask_px = ask_price_i;
      lv.ask_sz = ask_size_i;
      lv.ask_ok = ask_valid_i;
      lv.last   = last_level_i;
      book_accumulate(lv);
      levels_sent++;
      level_taken = 1;
    end
  end

  // ---------------------------------------------------------------
  // receiver stall: random runs, plus one long hold-off so that the
  // snapshot queue fills and the level input backs up
  // ---------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;
  bit hold_used = 0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_used && levels_sent >= 150) begin
      hold_used = 1;
      hold_left = 800;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = burst ? 0 : pick_gap();
      out_stall_i <= (stall_left > 0);
    end
  end

  // feature monitor
  always @(posedge clk_i) begin
    feature_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      features_seen++;
      if (feature_q.size() == 0) begin
        errors++;
        $display("unexpected feature transfer, record %0d", features_seen);
      end else begin
        w = feature_q.pop_front();
        if (imbalance_frac_o !== w.imb) report("imbalance", imbalance_frac_o, w.imb);
        if (depth_ratio_frac_o !== w.depth)
          report("band_ratio", depth_ratio_frac_o, w.depth);
        if (wall_frac_o !== w.wall) report("wall", wall_frac_o, w.wall);
        if (spread_bps_q8_o !== w.spread) report("spread", spread_bps_q8_o, w.spread);
        if (best_bid_out_o !== w.bb) report("bid_px0", best_bid_out_o, w.bb);
        if (best_ask_out_o !== w.ba) report("ask_px0", best_ask_out_o, w.ba);
        if (bid_top_volume_o !== w.bt) report("bid_top", bid_top_volume_o, w.bt);
        if (ask_top_volume_o !== w.at) report("ask_top", ask_top_volume_o, w.at);
        if (bid_band_volume_o !== w.bband) report("bid_band", bid_band_volume_o, w.bband);
        if (ask_band_volume_o !== w.aband) report("ask_band", ask_band_volume_o, w.aband);
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  function automatic level_t mk_level(logic [63:0] bpx, logic [63:0] bsz, bit bok,
                                      logic [63:0] apx, logic [63:0] asz, bit aok,
                                      bit last);
    level_t lv;
    lv.bid_px = obdf_pkg::PRICE_W'(bpx);
    lv.bid_sz = obdf_pkg::SIZE_W'(bsz);
    lv.bid_ok = bok;
    lv.ask_px = obdf_pkg::PRICE_W'(apx);
    lv.ask_sz = obdf_pkg::SIZE_W'(asz);
    lv.ask_ok = aok;
    lv.last   = last;
    return lv;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 15) return rand64();
    return $urandom_range(1, 1000000);
  endfunction

  // a well-formed book around a random mid, with some invalid and noisy ranks
  task automatic queue_snapshot(int depth);
    logic [63:0] mid, tick, bpx, apx;
    int r;
    r = $urandom_range(0, 9);
    mid = (r == 0) ? (rand64() & 64'hFF_FFFF_FFFF) | 64'd2 : $urandom_range(1000, 50000000);
    tick = $urandom_range(1, 1 + int'(mid / 2000));
    for (int k = 0; k < depth; k++) begin
      bpx = (mid > (k + 1) * tick) ? mid - (k + 1) * tick : 0;
      apx = mid + (k + 1) * tick;
      if ($urandom_range(0, 19) == 0) bpx = rand64();
      if ($urandom_range(0, 19) == 0) apx = rand64();
      level_q.push_back(mk_level(bpx, rand_size(), $urandom_range(0, 9) != 0,
                                 apx, rand_size(), $urandom_range(0, 9) != 0,
                                 k == depth - 1));
    end
  endtask

  // noise: unordered prices and sizes over the full field widths
  task automatic queue_noise(int depth);
    for (int k = 0; k < depth; k++)
      level_q.push_back(mk_level(rand64(), rand64(), $urandom_range(0, 1),
                                 rand64(), rand64(), $urandom_range(0, 1),
                                 k == depth - 1));
  endtask

  task automatic wait_idle();
    wait (level_q.size() == 0 && !in_valid_i && feature_q.size() == 0);
    // back end may still be busy on a snapshot in flight
    repeat (60) @(posedge clk_i);
  endtask

  // apb write then readback
  task automatic reg_write(logic idx, logic [31:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == obdf_pkg::REG_TOP_LEVELS) begin
      cfg_top = 64'(val[obdf_pkg::TOP_W-1:0]);
      if (rd[obdf_pkg::TOP_W-1:0] !== val[obdf_pkg::TOP_W-1:0])
        report("top_levels readback", rd, val);
    end else begin
      cfg_band = 64'(val[obdf_pkg::BAND_W-1:0]);
      if (rd[obdf_pkg::BAND_W-1:0] !== val[obdf_pkg::BAND_W-1:0])
        report("band readback", rd, val);
    end
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  localparam logic [63:0] PX_MAX = (64'd1 << obdf_pkg::PRICE_W) - 1;
  localparam logic [63:0] SZ_MAX = (64'd1 << obdf_pkg::SIZE_W) - 1;

  initial begin
    int tops[6];
    int bands[6];
    rst_ni = 1'b0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_valid_i = 0;
    bid_price_i = 0;
    bid_size_i = 0;
    bid_valid_i = 0;
    ask_price_i = 0;
    ask_size_i = 0;
    ask_valid_i = 0;
    last_level_i = 0;
    out_stall_i = 0;
    cfg_top = 10;
    cfg_band = 50;
    clear_book();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ranks under reset config
    // single-rank snapshot, tight book
    level_q.push_back(mk_level(9999, 100, 1, 10001, 300, 1, 1));
    // empty snapshot: both sides missing, zero mid, default fractions
    level_q.push_back(mk_level(0, 0, 0, 0, 0, 0, 1));
    // zero sizes everywhere
    level_q.push_back(mk_level(500, 0, 1, 510, 0, 1, 1));
    // price and size extremes
    level_q.push_back(mk_level(PX_MAX, SZ_MAX, 1, PX_MAX, SZ_MAX, 1, 0));
    level_q.push_back(mk_level(PX_MAX, SZ_MAX, 1, PX_MAX, SZ_MAX, 1, 1));
    // crossed book gives a negative spread
    level_q.push_back(mk_level(20000, 7, 1, 10000, 9, 1, 1));
    // missing rank-0 bid; its zero price enters the mid
    level_q.push_back(mk_level(12345, 50, 0, 10000, 40, 1, 0));
    level_q.push_back(mk_level(9990, 60, 1, 10010, 70, 1, 1));
    // missing rank-0 ask, extreme spread
    level_q.push_back(mk_level(PX_MAX, 5, 1, 0, 0, 0, 1));
    // band stops at first outside level and stays stopped; invalid level between
    level_q.push_back(mk_level(10000, 10, 1, 10010, 10, 1, 0));
    level_q.push_back(mk_level(9990, 11, 0, 10020, 12, 0, 0));
    level_q.push_back(mk_level(9000, 13, 1, 11000, 14, 1, 0));
    level_q.push_back(mk_level(9995, 15, 1, 10015, 16, 1, 1));
    // more ranks than top_levels
    for (int k = 0; k < 12; k++)
      level_q.push_back(mk_level(10000 - k, 100 + k, 1, 10001 + k, 200 - k, 1, k == 11));
    wait_idle();

    // settings sweep, extremes included; band value above 10000 is clamped
    tops  = '{1, 64, 0, 127, 3, 20};
    bands = '{0, 10000, 16383, 12000, 50, 200};
    for (int p = 0; p < 6; p++) begin
      reg_write(obdf_pkg::REG_TOP_LEVELS, tops[p]);
      reg_write(obdf_pkg::REG_DEPTH_BAND, bands[p]);
      while (level_q.size() < 65) begin
        if ($urandom_range(0, 9) == 0) queue_noise($urandom_range(1, 4));
        else if ($urandom_range(0, 9) == 0) queue_snapshot($urandom_range(20, 40));
        else queue_snapshot($urandom_range(1, 12));
      end
      wait_idle();
    end

    $display("covered %0d level transfers and %0d feature records", levels_sent,
             features_seen);
    $display("top_levels 0..127 and band 0..16383 swept, incl. a long output hold-off");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/obdf_pkg.sv
rtl/obdf_front.sv
rtl/obdf_queue.sv
rtl/obdf_back.sv
rtl/order_book_depth_features.sv
verif/tb_top.sv
